>>> hw/rtl/n2a_pkg.sv
`timescale 1ns / 1ps

package n2a_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int POS_WIDTH   = 4;

   // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT = 35;

   localparam logic [POS_WIDTH-1:0] POS_HEX_ZERO = 4'd9;
   localparam logic [POS_WIDTH-1:0] POS_HEX_X    = 4'd8;
   localparam logic [POS_WIDTH-1:0] POS_FINAL    = 4'd0;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO        = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X           = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A_MINUS_TEN = 8'h37;

   localparam logic FUNC_DEC = 1'b0;
   localparam logic FUNC_HEX = 1'b1;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = 1;

   typedef logic [MAX_DIGITS-1:0][DIGIT_WIDTH-1:0] digits_type;

   // one formatted run: position top goes out first, digits[0] last; hex positions 9, 8 give 0x
   typedef struct packed {
      logic                 func;
      logic [POS_WIDTH-1:0] top;
      digits_type           digits;
   } run_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONV,
      FRONT_PUSH
   } front_state_type;

   function automatic logic [CHAR_WIDTH-1:0] hex_char(input logic [DIGIT_WIDTH-1:0] nib);
      if (nib < 4'd10) begin
         return CHAR_ZERO + {4'b0000, nib};
      end else begin
         return CHAR_A_MINUS_TEN + {4'b0000, nib};
      end
   endfunction

endpackage

>>> hw/rtl/n2a_if.sv
`timescale 1ns / 1ps

interface n2a_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic [n2a_pkg::VALUE_WIDTH-1:0]  value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface n2a_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [n2a_pkg::CHAR_WIDTH-1:0]   character;
   logic                             last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hw/rtl/n2a_front.sv
`timescale 1ns / 1ps

module n2a_front (
   input  logic             clock,
   input  logic             reset,
   n2a_req_if.sink          req_bus,
   output logic             push_valid,
   input  logic             push_ready,
   output n2a_pkg::run_type push_data
);
   import n2a_pkg::*;

   front_state_type        state_ff, state_in;
   logic [VALUE_WIDTH-1:0] v_ff, v_in;
   logic [VALUE_WIDTH-1:0] prev_ff, prev_in;
   logic [POS_WIDTH-1:0]   n_ff, n_in;
   logic                   pend_ff, pend_in;
   run_type                run_ff, run_in;

   logic [2*VALUE_WIDTH-1:0] prod;
   logic [VALUE_WIDTH-1:0]   quot;
   logic [DIGIT_WIDTH-1:0]   ten_q_low;
   logic [DIGIT_WIDTH-1:0]   rem;

   assign prod = {{VALUE_WIDTH{1'b0}}, v_ff} * {{VALUE_WIDTH{1'b0}}, RECIP_TEN};
   assign quot = VALUE_WIDTH'(prod >> RECIP_SHIFT);

   // prev = 10*v + r with r < 10, so four low bits are enough
   assign ten_q_low = {v_ff[0], 3'b000} + {v_ff[2:0], 1'b0};
   assign rem       = prev_ff[DIGIT_WIDTH-1:0] - ten_q_low;

   assign push_data = run_ff;

   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      prev_in       = prev_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      run_in        = run_ff;
      req_bus.ready = (state_ff == FRONT_IDLE);
      push_valid    = (state_ff == FRONT_PUSH);
      case (state_ff)
         FRONT_IDLE: begin
            if (req_bus.valid) begin
               run_in.func = req_bus.func;
               if (req_bus.func == FUNC_HEX) begin
                  run_in.digits = digits_type'(req_bus.value);
                  run_in.top    = POS_HEX_ZERO;
                  state_in      = FRONT_PUSH;
               end else begin
                  run_in.digits = '0;
                  v_in          = req_bus.value;
                  n_in          = '0;
                  pend_in       = 1'b0;
                  state_in      = FRONT_CONV;
               end
            end
         end
         FRONT_CONV: begin
            if (pend_ff) begin
               run_in.digits[n_ff] = rem;
               n_in                = n_ff + 4'd1;
            end
            if (v_ff != '0) begin
               prev_in = v_ff;
               v_in    = quot;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // zero gives the single digit already cleared in slot 0
                  run_in.top = (n_ff == '0) ? POS_FINAL : n_ff - 4'd1;
                  state_in   = FRONT_PUSH;
               end
            end
         end
         FRONT_PUSH: begin
            if (push_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      prev_ff <= prev_in;
      n_ff    <= n_in;
      run_ff  <= run_in;
   end

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == FRONT_CONV |-> n_ff <= POS_WIDTH'(MAX_DIGITS))
      else $error("decimal digit count overflow");

   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == FRONT_CONV && v_ff == '0 && !pend_ff |=> state_ff == FRONT_PUSH)
      else $error("conversion did not finish");

   a_push_top: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_data.top < POS_WIDTH'(MAX_DIGITS))
      else $error("run length out of range");

endmodule

>>> hw/rtl/n2a_queue.sv
`timescale 1ns / 1ps

module n2a_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  n2a_pkg::run_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output n2a_pkg::run_type pop_data
);
   import n2a_pkg::*;

   run_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;
   logic                       push_fire;
   logic                       pop_fire;

   assign push_ready = (count_ff != (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");

endmodule

>>> hw/rtl/n2a_back.sv
`timescale 1ns / 1ps

module n2a_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  n2a_pkg::run_type pop_data,
   n2a_rsp_if.source        rsp_bus
);
   import n2a_pkg::*;

   logic                 busy_ff;
   run_type              run_ff;
   logic [POS_WIDTH-1:0] pos_ff;
   logic                 fire;
   logic                 done;

   assign rsp_bus.valid = busy_ff;
   assign rsp_bus.last  = (pos_ff == POS_FINAL);
   assign fire          = rsp_bus.valid && rsp_bus.ready;
   assign done          = fire && rsp_bus.last;
   assign pop_ready     = !busy_ff || done;

   always_comb begin
      if (run_ff.func == FUNC_HEX && pos_ff == POS_HEX_ZERO) begin
         rsp_bus.character = CHAR_ZERO;
      end else if (run_ff.func == FUNC_HEX && pos_ff == POS_HEX_X) begin
         rsp_bus.character = CHAR_X;
      end else begin
         rsp_bus.character = hex_char(run_ff.digits[pos_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (pop_valid && pop_ready) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         run_ff <= pop_data;
         pos_ff <= pop_data.top;
      end else if (fire) begin
         pos_ff <= pos_ff - 4'd1;
      end
   end

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      fire && !rsp_bus.last |=> busy_ff && pos_ff == $past(pos_ff) - 4'd1)
      else $error("character run broken");

endmodule

>>> hw/rtl/number_to_ascii_digits_top.sv
// A hex request is pushed to the queue as it stands; a decimal request is converted
//   first, one divide-by-ten step per cycle, lowest digit first.
// The front end takes no new request until its run is in the queue; the back end
//   sends one character beat per cycle while rsp_bus.ready is high (10 for hex);
//   a 2-deep queue lets both overlap.
// Reset (synchronous, active high) clears the control state and empties the queue.
`timescale 1ns / 1ps

module number_to_ascii_digits_top (
   input  logic      clock,
   input  logic      reset,
   n2a_req_if.sink   req_bus,
   n2a_rsp_if.source rsp_bus
);
   import n2a_pkg::*;

   logic    push_valid;
   logic    push_ready;
   run_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   run_type pop_data;

   n2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   n2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   n2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import n2a_pkg::*;

   localparam int          RANDOM_ITEMS = 480;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int          TAIL_CYCLES  = 16;

   localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";

   localparam logic [VALUE_WIDTH-1:0] POW10 [10] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
      32'd10000000, 32'd100000000, 32'd1000000000
   };

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } glyph_type;

   // text: right-justified ASCII run, zero means use the predictor
   typedef struct packed {
      logic                   func;
      logic [VALUE_WIDTH-1:0] value;
      logic [79:0]            text;
   } stim_row_type;

   localparam stim_row_type DIRECTED [18] = '{
      '{FUNC_DEC, 32'd0,          "0"},
      '{FUNC_HEX, 32'd0,          "0x00000000"},
      '{FUNC_DEC, 32'hFFFF_FFFF,  "4294967295"},
      '{FUNC_HEX, 32'hFFFF_FFFF,  "0xFFFFFFFF"},
      '{FUNC_DEC, 32'd1,          "1"},
      '{FUNC_DEC, 32'd9,          "9"},
      '{FUNC_DEC, 32'd10,         "10"},
      '{FUNC_HEX, 32'h1234_5678,  "0x12345678"},
      '{FUNC_HEX, 32'h9ABC_DEF0,  "0x9ABCDEF0"},
      '{FUNC_HEX, 32'h8000_0000,  "0x80000000"},
      '{FUNC_HEX, 32'h0000_000F,  "0x0000000F"},
      '{FUNC_DEC, 32'd123456789,  "123456789"},
      '{FUNC_DEC, 32'd99,         '0},
      '{FUNC_DEC, 32'd100,        '0},
      '{FUNC_DEC, 32'd999999999,  '0},
      '{FUNC_DEC, 32'd1000000000, '0},
      '{FUNC_DEC, 32'hFFFF_FFFE,  '0},
      '{FUNC_DEC, 32'h8000_0000,  '0}
   };

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   bit          sender_calm = 1'b0;
   glyph_type   pending_glyphs [$];
   glyph_type   wanted;

   n2a_req_if req_bus ();
   n2a_rsp_if rsp_bus ();

   number_to_ascii_digits_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_glyphs(input logic func, input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] rest;
      logic [DIGIT_WIDTH-1:0] digs [MAX_DIGITS];
      logic [DIGIT_WIDTH-1:0] nib;
      int                     n;
      if (func == FUNC_HEX) begin
         pending_glyphs.push_back('{CHAR_ZERO, 1'b0});
         pending_glyphs.push_back('{CHAR_X, 1'b0});
         for (int i = 7; i >= 0; i--) begin
            nib = value[i*4 +: 4];
            pending_glyphs.push_back('{HEX_GLYPHS[(15 - nib)*8 +: 8], i == 0});
         end
      end else begin
         rest = value;
         n    = 0;
         do begin
            digs[n] = DIGIT_WIDTH'(rest % 10);
            rest    = rest / 10;
            n++;
         end while (rest != 0);
         for (int i = n - 1; i >= 0; i--) begin
            pending_glyphs.push_back('{CHAR_ZERO + {4'b0000, digs[i]}, i == 0});
         end
      end
   endfunction

   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         3:       v = $urandom_range(0, 99);
         4:       v = POW10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
         5:       v = $urandom() >> $urandom_range(0, 31);
         6:       v = 32'hFFFF_FFFF - $urandom_range(0, 20);
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
   endfunction

   task automatic send_number(input logic func, input logic [VALUE_WIDTH-1:0] value,
                              input logic [79:0] text);
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (text != '0) begin
         for (int i = 9; i >= 0; i--) begin
            if (text[i*8 +: 8] != 8'h00) pending_glyphs.push_back('{text[i*8 +: 8], i == 0});
         end
      end else begin
         predict_glyphs(func, value);
      end
   endtask

   task automatic hold_sender(input int unsigned n, input bit to_empty);
      if (n > 0 || to_empty) begin
         req_bus.valid <= 1'b0;
         req_bus.func  <= 1'($urandom_range(0, 1));
         req_bus.value <= $urandom();
         repeat (n) @(posedge clock);
         while (to_empty && pending_glyphs.size() != 0) @(posedge clock);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_DEC;
      req_bus.value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         send_number(DIRECTED[i].func, DIRECTED[i].value, DIRECTED[i].text);
         hold_sender(pause_len(), 1'b0);
      end
      hold_sender(0, 1'b1);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 48 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         send_number(1'($urandom_range(0, 1)), pick_value(), '0);
         hold_sender(sender_calm ? 0 : pause_len(), k == RANDOM_ITEMS / 2);
      end
      hold_sender(0, 1'b1);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // sink side: random back-pressure with quiet stretches
   initial begin
      bit          calm;
      int unsigned n;
      calm = 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0) calm = !calm;
         n = calm ? 0 : pause_len();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_glyphs.size() == 0) begin
            note_error($sformatf("unexpected beat char=%02h last=%0b",
                                 rsp_bus.character, rsp_bus.last));
         end else begin
            wanted = pending_glyphs.pop_front();
            if (rsp_bus.character !== wanted.character || rsp_bus.last !== wanted.last) begin
               note_error($sformatf("char exp=%02h got=%02h, last exp=%0b got=%0b",
                                    wanted.character, rsp_bus.character,
                                    wanted.last, rsp_bus.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
